[design/biq_pkg.sv]
// Shared widths, register codes and types of the biquad filter with output clamp.
`default_nettype none

package biq_pkg;

	// Sample, coefficient and accumulator widths.
	localparam int DATA_WIDTH      = 32;
	localparam int COEF_WIDTH      = 32;
	localparam int COEF_FRAC_BITS  = 28;
	localparam int PROD_WIDTH      = DATA_WIDTH + COEF_WIDTH;
	// Five products need three guard bits.
	localparam int ACC_WIDTH       = PROD_WIDTH + 3;
	localparam int Q_WIDTH         = ACC_WIDTH - COEF_FRAC_BITS;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = (DATA_WIDTH > COEF_WIDTH) ? DATA_WIDTH : COEF_WIDTH;

	// Reset values.
	localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC_BITS;
	localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_COEF_B0      = 3'd0,
		REG_COEF_B1      = 3'd1,
		REG_COEF_B2      = 3'd2,
		REG_COEF_A1      = 3'd3,
		REG_COEF_A2      = 3'd4,
		REG_CLAMP_ENABLE = 3'd5,
		REG_LIMIT_LOW    = 3'd6,
		REG_LIMIT_HIGH   = 3'd7
	} cfg_reg_t;

	// Current register contents as seen by the datapath.
	typedef struct packed {
		logic [COEF_WIDTH-1:0] b0;
		logic [COEF_WIDTH-1:0] b1;
		logic [COEF_WIDTH-1:0] b2;
		logic [COEF_WIDTH-1:0] a1;
		logic [COEF_WIDTH-1:0] a2;
		logic                  clamp_enable;
		logic [DATA_WIDTH-1:0] limit_low;
		logic [DATA_WIDTH-1:0] limit_high;
	} biq_cfg_t;

	// Filter history: two past inputs and two past outputs.
	typedef struct packed {
		logic [DATA_WIDTH-1:0] x1;
		logic [DATA_WIDTH-1:0] x2;
		logic [DATA_WIDTH-1:0] y1;
		logic [DATA_WIDTH-1:0] y2;
	} biq_hist_t;

	// One result word.
	typedef struct packed {
		logic                  overflowed;
		logic                  limit_hit;
		logic [DATA_WIDTH-1:0] sample;
	} biq_result_t;

endpackage

`default_nettype wire

[design/biquad_iir_filter_with_output_clamp.sv]
// Top level of the direct form I biquad section with saturation and output clamp.
//
//   channel   direction  handshake          payload
//   s_        in         s_tvalid/s_tready  tdata: sample_in; tuser: clear_history
//   m_        out        m_tvalid/m_tready  tdata: sample_out; tuser: limit_hit, overflowed
//   cfg_      in         cfg_we             cfg_index, cfg_data (no read-back)
//
// One word a cycle while m_tready is high; words pass the input then the result register.
// The feedback path (five multipliers, the sum, saturation and clamp) lies
// between the input register and the result register and sets the clock rate.
// Reset returns the coefficients to a unity pass-through and zeroes the history.
// A stalled output holds its word; the input register still takes a word while
// the output register is empty or being emptied.
`default_nettype none

module biquad_iir_filter_with_output_clamp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream.
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [biq_pkg::DATA_WIDTH-1:0]      s_tdata,  // [31:0] sample_in
	input  wire logic                                s_tuser,  // [0] clear_history
	// Output stream.
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [biq_pkg::DATA_WIDTH-1:0]           m_tdata,  // [31:0] sample_out
	output logic [1:0]                               m_tuser,  // [0] limit_hit, [1] overflowed
	// Configuration write port.
	input  wire logic                                cfg_we,
	input  wire logic [biq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [biq_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	import biq_pkg::*;

	biq_cfg_t              cfg;
	biq_hist_t             hist_q;
	biq_result_t           mac_res;
	biq_result_t           res_s2;
	logic [DATA_WIDTH-1:0] x_s1;
	logic                  clear_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  out_ready;
	logic                  adv;

	biq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	biq_mac u_mac (
		.x      (x_s1),
		.hist   (hist_q),
		.cfg    (cfg),
		.result (mac_res)
	);

	// Handshake: the result register frees up when empty or taken.
	assign out_ready = !valid_s2 || m_tready;
	assign adv       = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			x_s1     <= s_tdata;
			clear_s1 <= s_tuser;
		end
	end

	// History shifts on each word that reaches the result register; a clear request zeroes it instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (adv) begin
			if (clear_s1) begin
				hist_q <= '0;
			end else begin
				hist_q.x2 <= hist_q.x1;
				hist_q.x1 <= x_s1;
				hist_q.y2 <= hist_q.y1;
				hist_q.y1 <= mac_res.sample;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= clear_s1 ? '0 : mac_res;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = res_s2.sample;
	assign m_tuser[0] = res_s2.limit_hit;
	assign m_tuser[1] = res_s2.overflowed;

	// A clear request empties the whole history.
	a_clear_hist: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && clear_s1) |=> (hist_q == '0))
		else $error("history not cleared by clear request");

	// A clear request yields an all-zero result word.
	a_clear_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && clear_s1) |=> (m_tvalid && m_tdata == '0 && m_tuser == 2'b00))
		else $error("clear request gave a non-zero result");

	// Input history shifts by one word per processed sample.
	a_hist_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !clear_s1) |=> (hist_q.x1 == $past(x_s1) && hist_q.x2 == $past(hist_q.x1)))
		else $error("input history did not shift");

	// The fed-back output equals the word just placed in the result register.
	a_feedback: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (hist_q.y1 == res_s2.sample))
		else $error("feedback value differs from the output word");

	// An empty input register always takes a word.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled while input register empty");

endmodule

`default_nettype wire

[design/biq_cfg.sv]
// Configuration register file of the biquad filter.
`default_nettype none

module biq_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [biq_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [biq_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	output biq_pkg::biq_cfg_t                         cfg
);
	import biq_pkg::*;

	biq_cfg_t cfg_q;

	// Register writes; bits above a register's width are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b0           <= COEF_ONE;
			cfg_q.b1           <= '0;
			cfg_q.b2           <= '0;
			cfg_q.a1           <= '0;
			cfg_q.a2           <= '0;
			cfg_q.clamp_enable <= 1'b0;
			cfg_q.limit_low    <= DATA_MIN;
			cfg_q.limit_high   <= DATA_MAX;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COEF_B0:      cfg_q.b0           <= cfg_data[COEF_WIDTH-1:0];
				REG_COEF_B1:      cfg_q.b1           <= cfg_data[COEF_WIDTH-1:0];
				REG_COEF_B2:      cfg_q.b2           <= cfg_data[COEF_WIDTH-1:0];
				REG_COEF_A1:      cfg_q.a1           <= cfg_data[COEF_WIDTH-1:0];
				REG_COEF_A2:      cfg_q.a2           <= cfg_data[COEF_WIDTH-1:0];
				REG_CLAMP_ENABLE: cfg_q.clamp_enable <= cfg_data[0];
				REG_LIMIT_LOW:    cfg_q.limit_low    <= cfg_data[DATA_WIDTH-1:0];
				REG_LIMIT_HIGH:   cfg_q.limit_high   <= cfg_data[DATA_WIDTH-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[design/biq_mac.sv]
// Combinational datapath: five products, sum, floor, saturation and clamp.
`default_nettype none

module biq_mac (
	input  wire logic [biq_pkg::DATA_WIDTH-1:0] x,
	input  wire biq_pkg::biq_hist_t             hist,
	input  wire biq_pkg::biq_cfg_t              cfg,
	output biq_pkg::biq_result_t                result
);
	import biq_pkg::*;

	logic signed [PROD_WIDTH-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_WIDTH-1:0]  acc;
	logic        [Q_WIDTH-1:0]    q;
	logic        [Q_WIDTH-DATA_WIDTH:0] q_top;
	logic                         sat;
	logic signed [DATA_WIDTH-1:0] y_sat;
	logic signed [DATA_WIDTH-1:0] lim_lo, lim_hi;

	// Five independent signed products.
	assign p_b0 = $signed(x)       * $signed(cfg.b0);
	assign p_b1 = $signed(hist.x1) * $signed(cfg.b1);
	assign p_b2 = $signed(hist.x2) * $signed(cfg.b2);
	assign p_a1 = $signed(hist.y1) * $signed(cfg.a1);
	assign p_a2 = $signed(hist.y2) * $signed(cfg.a2);

	// Exact sum; feedback terms are subtracted.
	assign acc = ACC_WIDTH'(p_b0) + ACC_WIDTH'(p_b1) + ACC_WIDTH'(p_b2)
		- ACC_WIDTH'(p_a1) - ACC_WIDTH'(p_a2);

	// Dropping the fraction bits of a two's complement value rounds toward minus infinity.
	assign q     = acc[ACC_WIDTH-1:COEF_FRAC_BITS];
	assign q_top = q[Q_WIDTH-1:DATA_WIDTH-1];
	assign sat   = !((&q_top) || !(|q_top));

	// Saturation to the sample range, by the sign of the sum.
	always_comb begin
		if (sat) begin
			y_sat = q[Q_WIDTH-1] ? $signed(DATA_MIN) : $signed(DATA_MAX);
		end else begin
			y_sat = $signed(q[DATA_WIDTH-1:0]);
		end
	end

	assign lim_lo = $signed(cfg.limit_low);
	assign lim_hi = $signed(cfg.limit_high);

	// Output clamp; the upper bound is tested first so inverted limits stay defined.
	always_comb begin
		result.overflowed = sat;
		result.limit_hit  = 1'b0;
		result.sample     = y_sat;
		if (cfg.clamp_enable) begin
			priority if (y_sat > lim_hi) begin
				result.sample    = lim_hi;
				result.limit_hit = 1'b1;
			end else if (y_sat < lim_lo) begin
				result.sample    = lim_lo;
				result.limit_hit = 1'b1;
			end else begin
				result.sample    = y_sat;
			end
		end
	end

endmodule

`default_nettype wire
